>>> sv/sasr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Symbol resolver package
// Shared types and codes for the sorted address symbol resolver.
// -----------------------------------------------------------------------------
package sasr_pkg;
   localparam int DEPTH_DEFAULT = 64;

   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_RESOLVE = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;

   localparam logic [2:0] KIND_NONE   = 3'd0;
   localparam logic [2:0] KIND_EXACT  = 3'd1;
   localparam logic [2:0] KIND_INSIDE = 3'd2;
   localparam logic [2:0] KIND_BEFORE = 3'd3;
   localparam logic [2:0] KIND_AFTER  = 3'd4;
   localparam logic [2:0] KIND_ORIGIN = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_SCAN,
      ST_INS_SHIFT,
      ST_INS_WRITE,
      ST_SEARCH,
      ST_PICK,
      ST_BELOW,
      ST_DECIDE,
      ST_EXACT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [15:0] symbol;
      logic [31:0] size;
      logic [63:0] start;
   } entry_type;

   typedef struct packed {
      logic        status;
      logic [2:0]  kind;
      logic [15:0] found_id;
      logic [63:0] offset;
      logic [31:0] entry_length;
      logic        last;
   } result_type;
endpackage
`default_nettype wire

>>> sv/sorted_address_symbol_resolver.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Sorted address symbol resolver
// Sorted symbol table with insert, clear and nearest-entry resolve.
// -----------------------------------------------------------------------------
// Channel  Direction  Contents
// req      in         opcode, address, length, symbol_id
// rsp      out        status, kind, found_id, offset, entry_length, last
//
// One memory read port sets the timing. A resolve does a binary search over
// the sorted entries, reads the nearby entries, gives one beat per exact match, else one beat.
// An insert scans the entries for its place and moves every later entry up one slot.
// A clear empties the table. Reset empties the table at once.
// The block takes no beat until every result beat has been taken.
// -----------------------------------------------------------------------------
module sorted_address_symbol_resolver
   import sasr_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // opcode[1:0], address[65:2], length[97:66], symbol_id[113:98], zero fill
   input  wire logic [119:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[0], kind[3:1], found_id[19:4], offset[83:20], entry_length[115:84]
   output logic [119:0]      rsp_tdata,
   output logic              rsp_tlast
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in, span_ff, span_in, idx_ff, idx_in;
   logic [63:0] addr_ff;
   logic [31:0] len_ff;
   logic [15:0] id_ff;
   logic        phase_ff, phase_in;
   entry_type   above_ff, above_in, below_ff, below_in;
   result_type  res_ff, res_in;
   logic        rv_ff, rv_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type     wr_data, rd_data;

   sasr_table #(.DEPTH(DEPTH)) u_table (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic [CW-1:0] half, mid;
   logic          rd_after, rd_below_q;
   logic [64:0]   below_end;
   logic [63:0]   d_above, d_below;
   logic          fire_in;

   assign fire_in    = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE) && !rv_ff;
   assign half       = span_ff >> 1;
   assign mid        = lo_ff + half;
   assign rd_below_q = rd_data.start < addr_ff;
   assign rd_after   = (rd_data.start != addr_ff) ? (rd_data.start > addr_ff) :
                       (rd_data.size != len_ff) ? (rd_data.size > len_ff) :
                       (rd_data.symbol > id_ff);
   assign below_end  = {1'b0, below_ff.start} + {33'd0, below_ff.size};
   assign d_above    = above_ff.start - addr_ff;
   assign d_below    = addr_ff - below_end[63:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
      end
      lo_ff    <= lo_in;
      span_ff  <= span_in;
      idx_ff   <= idx_in;
      phase_ff <= phase_in;
      above_ff <= above_in;
      below_ff <= below_in;
      res_ff   <= res_in;
      if (fire_in) begin
         addr_ff <= req_tdata[65:2];
         len_ff  <= req_tdata[97:66];
         id_ff   <= req_tdata[113:98];
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      lo_in    = lo_ff;
      span_in  = span_ff;
      idx_in   = idx_ff;
      phase_in = phase_ff;
      above_in = above_ff;
      below_in = below_ff;
      res_in   = res_ff;
      rv_in    = rv_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff[AW-1:0];
      wr_data  = rd_data;
      rd_addr  = idx_ff[AW-1:0];
      if (rv_ff && rsp_tready) begin
         rv_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (fire_in) begin
               res_in   = '0;
               res_in.last = 1'b1;
               idx_in   = '0;
               lo_in    = '0;
               span_in  = count_ff;
               phase_in = 1'b0;
               case (req_tdata[1:0])
                  OP_INSERT: begin
                     if (count_ff >= CW'(DEPTH)) begin
                        res_in.status = 1'b1;
                        state_in = ST_OUT;
                     end else begin
                        state_in = ST_INS_SCAN;
                     end
                  end
                  OP_RESOLVE: begin
                     if (count_ff == '0) begin
                        res_in.offset = req_tdata[65:2];
                        state_in = ST_OUT;
                     end else begin
                        state_in = ST_SEARCH;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     state_in = ST_OUT;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_INS_SCAN: begin
            // idx_ff is the address read; the data arrives in the next cycle.
            if (!phase_ff) begin
               if (idx_ff == count_ff) begin
                  state_in = ST_INS_WRITE;
               end else begin
                  phase_in = 1'b1;
               end
            end else begin
               phase_in = 1'b0;
               if (rd_after) begin
                  lo_in    = idx_ff;
                  idx_in   = count_ff;
                  state_in = ST_INS_SHIFT;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_INS_SHIFT: begin
            if (idx_ff == lo_ff) begin
               state_in = ST_INS_WRITE;
            end else if (!phase_ff) begin
               rd_addr  = AW'(idx_ff - 1'b1);
               phase_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               phase_in = 1'b0;
               idx_in   = idx_ff - 1'b1;
            end
         end
         ST_INS_WRITE: begin
            wr_en    = 1'b1;
            wr_data  = '{symbol: id_ff, size: len_ff, start: addr_ff};
            count_in = count_ff + 1'b1;
            state_in = ST_OUT;
         end
         ST_SEARCH: begin
            rd_addr = mid[AW-1:0];
            if (span_ff == '0) begin
               idx_in   = lo_ff;
               phase_in = 1'b0;
               state_in = ST_PICK;
            end else if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (rd_below_q) begin
                  lo_in   = mid + 1'b1;
                  span_in = span_ff - half - 1'b1;
               end else begin
                  span_in = half;
               end
            end
         end
         ST_PICK: begin
            // Read the entry at lo, or the last entry when lo is past the end.
            if (lo_ff >= count_ff) begin
               rd_addr = AW'(count_ff - 1'b1);
            end else begin
               rd_addr = lo_ff[AW-1:0];
            end
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               above_in = rd_data;
               below_in = '0;
               if (lo_ff >= count_ff) begin
                  below_in = rd_data;
                  state_in = ST_DECIDE;
               end else if (rd_data.start == addr_ff) begin
                  idx_in   = lo_ff;
                  state_in = ST_EXACT;
               end else if (lo_ff == '0) begin
                  state_in = ST_DECIDE;
               end else begin
                  state_in = ST_BELOW;
               end
            end
         end
         ST_BELOW: begin
            rd_addr = AW'(lo_ff - 1'b1);
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               below_in = rd_data;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            res_in = '0;
            res_in.last = 1'b1;
            state_in = ST_OUT;
            if (lo_ff != '0 && addr_ff >= below_ff.start &&
                {1'b0, addr_ff} < below_end) begin
               res_in.kind = KIND_INSIDE;
               res_in.found_id = below_ff.symbol;
               res_in.offset = addr_ff - below_ff.start;
               res_in.entry_length = below_ff.size;
            end else if (lo_ff >= count_ff) begin
               res_in.offset = addr_ff;
            end else if (d_above < d_below) begin
               res_in.kind = KIND_BEFORE;
               res_in.found_id = above_ff.symbol;
               res_in.offset = d_above;
               res_in.entry_length = above_ff.size;
            end else if (lo_ff != '0) begin
               res_in.kind = KIND_AFTER;
               res_in.found_id = below_ff.symbol;
               res_in.offset = d_below;
               res_in.entry_length = below_ff.size;
            end else begin
               res_in.kind = KIND_ORIGIN;
               res_in.offset = d_below;
            end
         end
         ST_EXACT: begin
            // above_ff holds the current match; peek the next entry.
            rd_addr = AW'(idx_ff + 1'b1);
            if (!rv_ff || rsp_tready) begin
               if (!phase_ff) begin
                  if (idx_ff + 1'b1 >= count_ff) begin
                     res_in = '0;
                     res_in.kind = KIND_EXACT;
                     res_in.found_id = above_ff.symbol;
                     res_in.entry_length = above_ff.size;
                     res_in.last = 1'b1;
                     rv_in = 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     phase_in = 1'b1;
                  end
               end else begin
                  phase_in = 1'b0;
                  res_in = '0;
                  res_in.kind = KIND_EXACT;
                  res_in.found_id = above_ff.symbol;
                  res_in.entry_length = above_ff.size;
                  res_in.last = (rd_data.start != addr_ff);
                  rv_in = 1'b1;
                  above_in = rd_data;
                  idx_in = idx_ff + 1'b1;
                  if (rd_data.start != addr_ff) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_OUT: begin
            rv_in    = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tlast  = res_ff.last;
   assign rsp_tdata  = {4'd0, res_ff.entry_length, res_ff.offset, res_ff.found_id,
                        res_ff.kind, res_ff.status};

   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("Input taken while a result beat is pending.");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("Entry count exceeds table depth.");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled result beat changed.");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && res_ff.status |-> rsp_tlast && res_ff.kind == KIND_NONE)
      else $error("Refused insert must be a single final beat.");
endmodule
`default_nettype wire

>>> sv/sasr_table.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Entry table
// Entry memory with one write port, one read port and a registered read.
// -----------------------------------------------------------------------------
module sasr_table
   import sasr_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire entry_type     wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output entry_type          rd_data
);
   entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
